// File: src/segment_intersection_test_top_defines.svh
// ----------------------------------------------------------------------------
// Segment intersection test: assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_DEFINES_SVH

// same-cycle implication
`define SIT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Widths, types and pipeline constants shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int IN_W       = 16;
  // only the low 16 bits of a coordinate are ever used
  localparam int CW         = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
  localparam int TOL_W      = 16;

  localparam int DIFF_W  = CW + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 1;
  localparam int OFS_W   = ((TOL_W > CW) ? TOL_W : CW) + 2;
  localparam int SPLIT_W = OFS_W;
  localparam int HI_W    = DET_W - SPLIT_W;
  localparam int PPL_W   = SPLIT_W + 1 + OFS_W;
  localparam int PPH_W   = HI_W + OFS_W;
  localparam int MUL_W   = DET_W + OFS_W;

  localparam int STAGES  = 7;
  localparam int BOXES   = 4;

  typedef logic        [CW-1:0]     coord_t;
  typedef logic        [TOL_W-1:0]  tol_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;
  typedef logic signed [MUL_W-1:0]  mul_t;

  localparam diff_t R_ZERO = '0;
  localparam diff_t R_ONE  = diff_t'(1);
  localparam det_t  D_ZERO = '0;

endpackage

// File: src/sit_seg_if.sv
// ----------------------------------------------------------------------------
// Segment pair channel
// Valid/ready channel carrying the four endpoints of two segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sit_seg_if;
  logic                        valid;
  logic                        ready;
  logic [sit_pkg::IN_W-1:0]    a_x1;
  logic [sit_pkg::IN_W-1:0]    a_y1;
  logic [sit_pkg::IN_W-1:0]    a_x2;
  logic [sit_pkg::IN_W-1:0]    a_y2;
  logic [sit_pkg::IN_W-1:0]    b_x1;
  logic [sit_pkg::IN_W-1:0]    b_y1;
  logic [sit_pkg::IN_W-1:0]    b_x2;
  logic [sit_pkg::IN_W-1:0]    b_y2;

  modport source (output valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
                  input ready);
  modport sink (input valid, a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2,
                output ready);
endinterface

// File: src/sit_hit_if.sv
// ----------------------------------------------------------------------------
// Hit result channel
// Valid/ready channel carrying the one-bit intersection result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sit_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// File: src/sit_pp_mul.sv
// ----------------------------------------------------------------------------
// Split multiplier
// Wide signed by narrow signed product in two register stages: two partial
// products, then the shifted sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sit_pp_mul (
  input  logic            clk,
  input  logic            en_pp,
  input  logic            en_sum,
  input  sit_pkg::det_t   a,
  input  sit_pkg::ofs_t   b,
  output sit_pkg::mul_t   p
);

  logic signed [sit_pkg::SPLIT_W:0]     a_lo;
  logic signed [sit_pkg::HI_W-1:0]      a_hi;
  logic signed [sit_pkg::PPL_W-1:0]     pp_lo;
  logic signed [sit_pkg::PPH_W-1:0]     pp_hi;

  // low part is taken as unsigned, the sign lives in the high part
  assign a_lo = {1'b0, a[sit_pkg::SPLIT_W-1:0]};
  assign a_hi = a[sit_pkg::DET_W-1:sit_pkg::SPLIT_W];

  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_lo <= a_lo * b;
      pp_hi <= a_hi * b;
    end
    if (en_sum) begin
      p <= (sit_pkg::mul_t'(pp_hi) <<< sit_pkg::SPLIT_W) + sit_pkg::mul_t'(pp_lo);
    end
  end

endmodule

// File: src/segment_intersection_test_top.sv
// Segment intersection test. Takes two segments as four Q12.4 endpoints and
// returns one hit bit: 1 when the crossing point of the two carrying lines
// lies inside both segments' bounding boxes widened by the tolerance register
// (inclusive). Both segments vertical, or parallel lines, give no hit. The
// point is tested exactly by cross-multiplication. The datapath is a 7-stage
// pipeline: one segment pair is taken every cycle unless input is held off;
// each stage holds its word on a downstream stall and empty stages keep
// filling, so input is only held off once all stages are full.
// Write the tolerance only while no word is in flight.
// ----------------------------------------------------------------------------
// Segment intersection test top level
// Difference, determinant, normalize, split multiply and compare stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_intersection_test_top_defines.svh"

module segment_intersection_test_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  sit_pkg::tol_t          cfg_wdata,
  sit_seg_if.sink                seg,
  sit_hit_if.source              res
);

  sit_pkg::tol_t tol;

  logic [sit_pkg::STAGES-1:0] vld;
  logic [sit_pkg::STAGES-1:0] en;

  // ---------------- stage 1 inputs
  sit_pkg::coord_t c_ax1, c_ay1, c_ax2, c_ay2, c_bx1, c_by1, c_bx2, c_by2;
  sit_pkg::coord_t e1 [sit_pkg::BOXES];
  sit_pkg::coord_t e2 [sit_pkg::BOXES];
  logic            va, vb;

  sit_pkg::diff_t  s1_rax, s1_ray, s1_rbx, s1_rby, s1_ex, s1_ey;
  sit_pkg::coord_t s1_ax1, s1_ay1;
  sit_pkg::coord_t s1_mn [sit_pkg::BOXES];
  sit_pkg::coord_t s1_mx [sit_pkg::BOXES];

  // ---------------- stage 2
  sit_pkg::prod_t  s2_pab, s2_pba, s2_ptx, s2_pty;
  sit_pkg::diff_t  s2_rax, s2_ray;
  sit_pkg::ofs_t   s2_lo [sit_pkg::BOXES];
  sit_pkg::ofs_t   s2_hi [sit_pkg::BOXES];
  sit_pkg::coord_t base [sit_pkg::BOXES];

  // ---------------- stage 3
  sit_pkg::det_t   s3_d, s3_tn;
  sit_pkg::diff_t  s3_rax, s3_ray;
  sit_pkg::ofs_t   s3_lo [sit_pkg::BOXES];
  sit_pkg::ofs_t   s3_hi [sit_pkg::BOXES];

  // ---------------- stage 4
  sit_pkg::det_t   s4_d, s4_tn;
  logic            s4_par;
  sit_pkg::diff_t  s4_rax, s4_ray;
  sit_pkg::ofs_t   s4_lo [sit_pkg::BOXES];
  sit_pkg::ofs_t   s4_hi [sit_pkg::BOXES];

  // ---------------- stages 5 and 6
  logic            s5_par, s6_par;
  sit_pkg::mul_t   mid_x, mid_y;
  sit_pkg::mul_t   bnd_lo [sit_pkg::BOXES];
  sit_pkg::mul_t   bnd_hi [sit_pkg::BOXES];
  logic            hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // ---------------- pipeline control: a stage moves when it is empty or drains
  always_comb begin
    en[sit_pkg::STAGES-1] = !vld[sit_pkg::STAGES-1] || res.ready;
    for (int k = sit_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= seg.valid;
      end
      for (int k = 1; k < sit_pkg::STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign seg.ready = en[0];
  assign res.valid = vld[sit_pkg::STAGES-1];

  // ---------------- stage 1: directions and box extents
  assign c_ax1 = seg.a_x1[sit_pkg::CW-1:0];
  assign c_ay1 = seg.a_y1[sit_pkg::CW-1:0];
  assign c_ax2 = seg.a_x2[sit_pkg::CW-1:0];
  assign c_ay2 = seg.a_y2[sit_pkg::CW-1:0];
  assign c_bx1 = seg.b_x1[sit_pkg::CW-1:0];
  assign c_by1 = seg.b_y1[sit_pkg::CW-1:0];
  assign c_bx2 = seg.b_x2[sit_pkg::CW-1:0];
  assign c_by2 = seg.b_y2[sit_pkg::CW-1:0];

  assign va = (c_ax1 == c_ax2);
  assign vb = (c_bx1 == c_bx2);

  // boxes: A in x, A in y, B in x, B in y
  assign e1[0] = c_ax1;
  assign e2[0] = c_ax2;
  assign e1[1] = c_ay1;
  assign e2[1] = c_ay2;
  assign e1[2] = c_bx1;
  assign e2[2] = c_bx2;
  assign e1[3] = c_by1;
  assign e2[3] = c_by2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // a vertical segment takes direction (0, 1)
      s1_rax <= va ? sit_pkg::R_ZERO : sit_pkg::diff_t'(c_ax2) - sit_pkg::diff_t'(c_ax1);
      s1_ray <= va ? sit_pkg::R_ONE  : sit_pkg::diff_t'(c_ay2) - sit_pkg::diff_t'(c_ay1);
      s1_rbx <= vb ? sit_pkg::R_ZERO : sit_pkg::diff_t'(c_bx2) - sit_pkg::diff_t'(c_bx1);
      s1_rby <= vb ? sit_pkg::R_ONE  : sit_pkg::diff_t'(c_by2) - sit_pkg::diff_t'(c_by1);
      s1_ex  <= sit_pkg::diff_t'(c_bx1) - sit_pkg::diff_t'(c_ax1);
      s1_ey  <= sit_pkg::diff_t'(c_by1) - sit_pkg::diff_t'(c_ay1);
      s1_ax1 <= c_ax1;
      s1_ay1 <= c_ay1;
      for (int i = 0; i < sit_pkg::BOXES; i++) begin
        s1_mn[i] <= (e1[i] < e2[i]) ? e1[i] : e2[i];
        s1_mx[i] <= (e1[i] < e2[i]) ? e2[i] : e1[i];
      end
    end
  end

  // ---------------- stage 2: cross products and box offsets from the base point
  always_comb begin
    for (int i = 0; i < sit_pkg::BOXES; i++) begin
      base[i] = (i % 2 == 0) ? s1_ax1 : s1_ay1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_pab <= s1_rax * s1_rby;
      s2_pba <= s1_ray * s1_rbx;
      s2_ptx <= s1_ex * s1_rby;
      s2_pty <= s1_ey * s1_rbx;
      s2_rax <= s1_rax;
      s2_ray <= s1_ray;
      for (int i = 0; i < sit_pkg::BOXES; i++) begin
        s2_lo[i] <= sit_pkg::ofs_t'(s1_mn[i]) - sit_pkg::ofs_t'(tol)
                    - sit_pkg::ofs_t'(base[i]);
        s2_hi[i] <= sit_pkg::ofs_t'(s1_mx[i]) + sit_pkg::ofs_t'(tol)
                    - sit_pkg::ofs_t'(base[i]);
      end
    end
  end

  // ---------------- stage 3: determinant and numerator
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_d   <= sit_pkg::det_t'(s2_pab) - sit_pkg::det_t'(s2_pba);
      s3_tn  <= sit_pkg::det_t'(s2_ptx) - sit_pkg::det_t'(s2_pty);
      s3_rax <= s2_rax;
      s3_ray <= s2_ray;
      s3_lo  <= s2_lo;
      s3_hi  <= s2_hi;
    end
  end

  // ---------------- stage 4: make the determinant non-negative
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_d   <= (s3_d < sit_pkg::D_ZERO) ? -s3_d  : s3_d;
      s4_tn  <= (s3_d < sit_pkg::D_ZERO) ? -s3_tn : s3_tn;
      // covers both-vertical too, whose determinant is zero
      s4_par <= (s3_d == sit_pkg::D_ZERO);
      s4_rax <= s3_rax;
      s4_ray <= s3_ray;
      s4_lo  <= s3_lo;
      s4_hi  <= s3_hi;
    end
  end

  // ---------------- stages 5 and 6: split products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_par <= s4_par;
    end
    if (en[5]) begin
      s6_par <= s5_par;
    end
  end

  sit_pp_mul u_mid_x (
    .clk    (clk),
    .en_pp  (en[4]),
    .en_sum (en[5]),
    .a      (s4_tn),
    .b      (sit_pkg::ofs_t'(s4_rax)),
    .p      (mid_x)
  );

  sit_pp_mul u_mid_y (
    .clk    (clk),
    .en_pp  (en[4]),
    .en_sum (en[5]),
    .a      (s4_tn),
    .b      (sit_pkg::ofs_t'(s4_ray)),
    .p      (mid_y)
  );

  for (genvar g = 0; g < sit_pkg::BOXES; g++) begin : g_box
    sit_pp_mul u_lo (
      .clk    (clk),
      .en_pp  (en[4]),
      .en_sum (en[5]),
      .a      (s4_d),
      .b      (s4_lo[g]),
      .p      (bnd_lo[g])
    );

    sit_pp_mul u_hi (
      .clk    (clk),
      .en_pp  (en[4]),
      .en_sum (en[5]),
      .a      (s4_d),
      .b      (s4_hi[g]),
      .p      (bnd_hi[g])
    );
  end

  // ---------------- stage 7: inclusive range compares into the output word
  always_comb begin
    hit_next = !s6_par;
    for (int i = 0; i < sit_pkg::BOXES; i++) begin
      if (i % 2 == 0) begin
        hit_next = hit_next && (bnd_lo[i] <= mid_x) && (mid_x <= bnd_hi[i]);
      end else begin
        hit_next = hit_next && (bnd_lo[i] <= mid_y) && (mid_y <= bnd_hi[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[sit_pkg::STAGES-1]) begin
      res.hit <= hit_next;
    end
  end

  // ---------------- checks
  `SIT_ASSERT_NEXT(a_stage1_hold, vld[0] && !en[0], vld[0], "stage 1 word dropped on stall")
  `SIT_ASSERT_NEXT(a_parallel_miss, en[sit_pkg::STAGES-1] && vld[sit_pkg::STAGES-2] && s6_par, res.valid && !res.hit, "parallel lines reported as hit")
  `SIT_ASSERT_IMPL(a_full_blocks, (&vld) && !res.ready, !seg.ready, "input taken into a full stalled pipeline")

endmodule

// File: tb/segment_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection checker
// Watches the segment pair and hit channels, predicts the hit bit of every
// accepted pair from the current tolerance and compares it in order with the
// hit words coming out. Reports mismatches and the number still in flight.
// ----------------------------------------------------------------------------

module segment_intersection_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  sit_pkg::tol_t  cfg_wdata,
  sit_seg_if             seg,
  sit_hit_if             res,
  output int             fails,
  output int             pending
);

  sit_pkg::tol_t tol_q;
  bit            hit_q[$];
  int            miss_n;

  // Point reached from base by step * num / den lies in the widened span e1..e2.
  function automatic bit on_span(longint base, longint step, longint num,
                                 longint den, longint e1, longint e2,
                                 longint tol);
    longint lo, hi, m;
    lo = ((e1 < e2) ? e1 : e2) - tol;
    hi = ((e1 < e2) ? e2 : e1) + tol;
    m  = step * num;
    return (den * (lo - base) <= m) && (m <= den * (hi - base));
  endfunction

  function automatic bit segments_touch(longint ax1, longint ay1, longint ax2,
                                        longint ay2, longint bx1, longint by1,
                                        longint bx2, longint by2, longint tol);
    bit     vert_a, vert_b;
    longint dax, day, dbx, dby, det, num;
    vert_a = (ax1 == ax2);
    vert_b = (bx1 == bx2);
    if (vert_a && vert_b) return 1'b0;
    // vertical lines run along (0, 1)
    dax = vert_a ? 0 : ax2 - ax1;
    day = vert_a ? 1 : ay2 - ay1;
    dbx = vert_b ? 0 : bx2 - bx1;
    dby = vert_b ? 1 : by2 - by1;
    det = dax * dby - day * dbx;
    if (det == 0) return 1'b0;
    num = (bx1 - ax1) * dby - (by1 - ay1) * dbx;
    if (det < 0) begin
      det = -det;
      num = -num;
    end
    return on_span(ax1, dax, num, det, ax1, ax2, tol)
        && on_span(ay1, day, num, det, ay1, ay2, tol)
        && on_span(ax1, dax, num, det, bx1, bx2, tol)
        && on_span(ay1, day, num, det, by1, by2, tol);
  endfunction

  task automatic flag_miss(input string what, input logic expd, input logic got);
    miss_n++;
    if (miss_n <= 10)
      $display("%0t: %s: expected %b, got %b", $time, what, expd, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tol_q  <= '0;
      hit_q.delete();
      miss_n = 0;
    end else begin
      if (cfg_we) tol_q <= cfg_wdata;
      if (seg.valid && seg.ready)
        hit_q.push_back(segments_touch(seg.a_x1, seg.a_y1, seg.a_x2, seg.a_y2,
                                       seg.b_x1, seg.b_y1, seg.b_x2, seg.b_y2,
                                       tol_q));
      if (res.valid && res.ready) begin
        if (hit_q.size() == 0)
          flag_miss("hit word with nothing expected", 1'bx, res.hit);
        else if (res.hit !== hit_q[0]) begin
          flag_miss("hit mismatch", hit_q[0], res.hit);
          void'(hit_q.pop_front());
        end else
          void'(hit_q.pop_front());
      end
    end
    fails   <= miss_n;
    pending <= hit_q.size();
  end

endmodule

// File: tb/tb_segment_intersection_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test bench
// Drives directed and random segment pairs under several tolerance settings,
// with random gaps and stalls on both channels and one long output hold-off,
// and gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------

module tb_segment_intersection_test_top;

  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_COORD    = 65535;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  sit_pkg::tol_t cfg_wdata;
  int            fails;
  int            pending;
  int            gap_pct;
  int            rx_stall_pct;
  bit            squeeze_now;

  sit_seg_if seg_ch ();
  sit_hit_if hit_ch ();

  segment_intersection_test_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .seg       (seg_ch),
    .res       (hit_ch)
  );

  segment_intersection_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .seg       (seg_ch),
    .res       (hit_ch),
    .fails     (fails),
    .pending   (pending)
  );

  // starts low so the first rising edge comes after reset is driven
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 1;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return MAX_COORD - 1;
      default: return MAX_COORD;
    endcase
  endfunction

  task automatic offer_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                            input int bx1, input int by1, input int bx2, input int by2);
    seg_ch.valid <= 1'b1;
    seg_ch.a_x1  <= ax1[15:0];
    seg_ch.a_y1  <= ay1[15:0];
    seg_ch.a_x2  <= ax2[15:0];
    seg_ch.a_y2  <= ay2[15:0];
    seg_ch.b_x1  <= bx1[15:0];
    seg_ch.b_y1  <= by1[15:0];
    seg_ch.b_x2  <= bx2[15:0];
    seg_ch.b_y2  <= by2[15:0];
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    if ($urandom_range(99) < gap_pct) begin
      seg_ch.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic offer_random_pair();
    int ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    int cx, cy, pick;
    ax1 = $urandom_range(MAX_COORD);
    ay1 = $urandom_range(MAX_COORD);
    ax2 = $urandom_range(MAX_COORD);
    ay2 = $urandom_range(MAX_COORD);
    bx1 = $urandom_range(MAX_COORD);
    by1 = $urandom_range(MAX_COORD);
    bx2 = $urandom_range(MAX_COORD);
    by2 = $urandom_range(MAX_COORD);
    cx  = $urandom_range(8192, 57343);
    cy  = $urandom_range(8192, 57343);
    pick = $urandom_range(99);
    if (pick >= 25 && pick < 70) begin
      // both segments pass through (cx, cy); b is sometimes nudged off it
      ax1 = cx + jitter(4000);
      ay1 = cy + jitter(4000);
      ax2 = 2 * cx - ax1;
      ay2 = 2 * cy - ay1;
      bx1 = cx + jitter(4000);
      by1 = cy + jitter(4000);
      bx2 = 2 * cx - bx1;
      by2 = 2 * cy - by1;
      if (pick >= 60) begin
        // parallel to a, or collinear from its midpoint outward
        bx1 = (pick >= 65) ? cx : ax1 + jitter(16);
        by1 = (pick >= 65) ? cy : ay1 + jitter(16);
        bx2 = bx1 + ax2 - ax1;
        by2 = by1 + ay2 - ay1;
      end else if ($urandom_range(1) == 0) begin
        bx1 += jitter(8);
        by2 += jitter(8);
      end
    end else if (pick >= 70 && pick < 85) begin
      ax1 = $urandom_range(48);
      ay1 = $urandom_range(48);
      ax2 = $urandom_range(48);
      ay2 = $urandom_range(48);
      bx1 = $urandom_range(48);
      by1 = $urandom_range(48);
      bx2 = $urandom_range(48);
      by2 = $urandom_range(48);
    end else if (pick >= 85) begin
      ax1 = extreme_coord();
      ay1 = extreme_coord();
      ax2 = extreme_coord();
      ay2 = extreme_coord();
      bx1 = extreme_coord();
      by1 = extreme_coord();
      bx2 = extreme_coord();
      by2 = extreme_coord();
    end
    case ($urandom_range(9))
      6: ax2 = ax1;
      7: bx2 = bx1;
      8: begin
        ax2 = ax1;
        bx2 = bx1;
      end
      9: begin
        ax2 = ax1;
        ay2 = ay1;
      end
      default: ;
    endcase
    offer_pair(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2);
  endtask

  // stop offering and wait for every hit word in flight
  task automatic drain();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_tolerance(input sit_pkg::tol_t tol);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    hit_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (squeeze_now) begin
        squeeze_now = 1'b0;
        hit_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(99) < rx_stall_pct) begin
        hit_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        hit_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_segment_intersection_test_top: FAIL");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    seg_ch.valid <= 1'b0;
    seg_ch.a_x1  <= '0;
    seg_ch.a_y1  <= '0;
    seg_ch.a_x2  <= '0;
    seg_ch.a_y2  <= '0;
    seg_ch.b_x1  <= '0;
    seg_ch.b_y1  <= '0;
    seg_ch.b_x2  <= '0;
    seg_ch.b_y2  <= '0;
    gap_pct      = 20;
    rx_stall_pct = 20;
    squeeze_now  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_tolerance(16'd0);

    // directed: extremes, verticals, parallels, degenerate and touching cases
    offer_pair(0, 0, 0, 0, 0, 0, 0, 0);
    offer_pair(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
               MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
    offer_pair(0, 0, MAX_COORD, MAX_COORD, 0, MAX_COORD, MAX_COORD, 0);
    offer_pair(100, 0, 100, 500, 100, 100, 100, 800);
    offer_pair(500, 0, 500, 1000, 0, 500, 1000, 500);
    offer_pair(0, 500, 1000, 500, 500, 0, 500, 1000);
    offer_pair(500, 0, 500, 1000, 0, 500, 499, 500);
    offer_pair(0, 500, 1000, 500, 2000, 0, 2000, MAX_COORD);
    offer_pair(0, 0, 100, 100, 0, 10, 100, 110);
    offer_pair(0, 0, 100, 100, 50, 50, 150, 150);
    offer_pair(50, 50, 50, 50, 0, 0, 100, 100);
    offer_pair(50, 51, 50, 51, 0, 0, 100, 100);
    offer_pair(0, 0, 100, 100, 100, 100, 200, 0);
    offer_pair(0, 0, 100, 100, 101, 99, 200, 0);
    offer_pair(0, MAX_COORD, MAX_COORD, 0, 0, 0, MAX_COORD, MAX_COORD - 1);
    offer_pair(0, 0, MAX_COORD, 1, 0, 1, MAX_COORD, 0);
    offer_pair(MAX_COORD, 0, MAX_COORD, MAX_COORD, 0, MAX_COORD, MAX_COORD, 0);
    offer_pair(MAX_COORD, MAX_COORD, 0, 0, MAX_COORD, 0, 0, MAX_COORD);
    offer_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
               16'h8000, 16'h8000);
    offer_pair(0, 0, 1, 0, 0, 0, 0, 1);

    gap_pct      = 25;
    rx_stall_pct = 25;
    repeat (100) offer_random_pair();

    // one unit of tolerance; output held off while input runs back to back
    set_tolerance(16'd16);
    gap_pct     = 0;
    squeeze_now = 1'b1;
    repeat (60) offer_random_pair();
    gap_pct      = 30;
    rx_stall_pct = 30;
    repeat (60) offer_random_pair();

    set_tolerance(16'hFFFF);
    repeat (50) offer_random_pair();

    set_tolerance(sit_pkg::tol_t'($urandom_range(1, 200)));
    gap_pct      = 0;
    rx_stall_pct = 0;
    repeat (60) offer_random_pair();

    set_tolerance(16'd3);
    gap_pct      = 40;
    rx_stall_pct = 40;
    repeat (60) offer_random_pair();

    drain();
    repeat (sit_pkg::STAGES + 8) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("tb_segment_intersection_test_top: PASS");
    else
      $display("tb_segment_intersection_test_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/sit_pkg.sv
src/sit_seg_if.sv
src/sit_hit_if.sv
src/sit_pp_mul.sv
src/segment_intersection_test_top.sv
tb/segment_intersection_checker.sv
tb/tb_segment_intersection_test_top.sv
